// File: hdl/hlne_pkg.sv
// ----------------------------------------------------------------------------
// hlne_pkg
// Shared types, operation codes, the logistic table and a saturation helper.
// ----------------------------------------------------------------------------
package hlne_pkg;

  localparam int TAPS       = 16;
  localparam int TAP_W      = 4;
  localparam int VAL_W      = 16;
  localparam int NODE_MAX_W = 8;
  localparam int ACT_MAX_W  = 7;

  localparam logic [1:0] OP_SET_INPUT = 2'd0;
  localparam logic [1:0] OP_LOAD      = 2'd1;
  localparam logic [1:0] OP_RUN       = 2'd2;
  localparam logic [1:0] OP_LEARN     = 2'd3;

  typedef struct packed {
    logic                  wr_input;
    logic                  wr_weight;
    logic                  issue;
    logic                  learn;
    logic                  first_layer;
    logic [NODE_MAX_W-1:0] node;
    logic [TAP_W-1:0]      tap;
    logic [ACT_MAX_W-1:0]  prev_base;
    logic                  acc_clr;
    logic                  wb;
    logic                  wb_out;
    logic [2:0]            out_num;
    logic                  out_last;
    logic                  z_rd;
    logic                  z_mul;
    logic                  z_round;
    logic                  z_tab;
    logic                  z_rg;
  } hlne_cmd_t;

  typedef struct packed {
    logic pipe_empty;
  } hlne_stat_t;

  // logistic(x) - 0.5 in Q4.12 at steps of 0.5
  function automatic logic [10:0] half_logistic(input logic [4:0] idx);
    logic [10:0] v;
    case (idx)
      5'd0:    v = 11'd0;
      5'd1:    v = 11'd502;
      5'd2:    v = 11'd946;
      5'd3:    v = 11'd1301;
      5'd4:    v = 11'd1560;
      5'd5:    v = 11'd1737;
      5'd6:    v = 11'd1854;
      5'd7:    v = 11'd1928;
      5'd8:    v = 11'd1974;
      5'd9:    v = 11'd2003;
      5'd10:   v = 11'd2021;
      5'd11:   v = 11'd2031;
      5'd12:   v = 11'd2038;
      5'd13:   v = 11'd2042;
      5'd14:   v = 11'd2044;
      5'd15:   v = 11'd2046;
      default: v = 11'd2047;
    endcase
    return v;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
    logic signed [15:0] r;
    if (v > 48'sd32767) r = 16'sh7fff;
    else if (v < -48'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage

// File: hdl/hlne_ctrl.sv
// ----------------------------------------------------------------------------
// hlne_ctrl
// Sequencer: walks neurodes and taps for run and learn items.
// ----------------------------------------------------------------------------
module hlne_ctrl import hlne_pkg::*; #(
  parameter int INPUT_COUNT  = 16,
  parameter int PER_LAYER    = 16,
  parameter int LAYER_COUNT  = 4,
  parameter int OUTPUT_COUNT = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] op,
  input  hlne_stat_t stat,
  output logic       busy,
  output hlne_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_R_TAP   = 4'd1;
  localparam logic [3:0] S_R_DRAIN = 4'd2;
  localparam logic [3:0] S_R_WB    = 4'd3;
  localparam logic [3:0] S_L_ACT   = 4'd4;
  localparam logic [3:0] S_L_MULZ  = 4'd5;
  localparam logic [3:0] S_L_Z     = 4'd6;
  localparam logic [3:0] S_L_TAB   = 4'd7;
  localparam logic [3:0] S_L_RG    = 4'd8;
  localparam logic [3:0] S_L_TAP   = 4'd9;
  localparam logic [3:0] S_L_DRAIN = 4'd10;

  logic [3:0]            state_r, state_nxt;
  logic [NODE_MAX_W-1:0] node_r, node_nxt;
  logic [3:0]            layer_r, layer_nxt;
  logic [3:0]            pos_r, pos_nxt;
  logic [TAP_W-1:0]      tap_r, tap_nxt;
  logic [ACT_MAX_W-1:0]  base_r, base_nxt;
  logic                  accept;
  logic                  first;
  logic                  last_tap;
  logic                  out_layer;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign first     = (layer_r == 4'd0);
  assign out_layer = (layer_r == 4'(LAYER_COUNT));
  assign last_tap  = first ? (tap_r == 4'(INPUT_COUNT - 1)) : (tap_r == 4'(PER_LAYER - 1));

  always_comb begin
    state_nxt = state_r;
    node_nxt  = node_r;
    layer_nxt = layer_r;
    pos_nxt   = pos_r;
    tap_nxt   = tap_r;
    base_nxt  = base_r;

    cmd             = '0;
    cmd.wr_input    = accept && (op == OP_SET_INPUT);
    cmd.wr_weight   = accept && (op == OP_LOAD);
    cmd.node        = node_r;
    cmd.tap         = tap_r;
    cmd.prev_base   = base_r;
    cmd.first_layer = first;
    cmd.learn       = (state_r == S_L_TAP) || (state_r == S_L_DRAIN);
    cmd.out_num     = pos_r[2:0];
    cmd.out_last    = (pos_r == 4'(OUTPUT_COUNT - 1));

    unique case (state_r)
      S_IDLE: begin
        node_nxt  = '0;
        layer_nxt = '0;
        pos_nxt   = '0;
        tap_nxt   = '0;
        base_nxt  = '0;
        if (accept && op == OP_RUN) begin
          cmd.acc_clr = 1'b1;
          state_nxt   = S_R_TAP;
        end else if (accept && op == OP_LEARN) begin
          state_nxt = S_L_ACT;
        end
      end
      S_R_TAP, S_L_TAP: begin
        cmd.issue = 1'b1;
        tap_nxt   = tap_r + 4'd1;
        if (last_tap) begin
          state_nxt = (state_r == S_R_TAP) ? S_R_DRAIN : S_L_DRAIN;
        end
      end
      S_R_DRAIN: begin
        if (stat.pipe_empty) state_nxt = S_R_WB;
      end
      S_R_WB, S_L_DRAIN: begin
        if (state_r == S_R_WB) begin
          cmd.wb      = 1'b1;
          cmd.wb_out  = out_layer;
          cmd.acc_clr = 1'b1;
        end
        if (state_r == S_R_WB || stat.pipe_empty) begin
          tap_nxt  = '0;
          node_nxt = node_r + 8'd1;
          if (state_r == S_R_WB && out_layer && pos_r == 4'(OUTPUT_COUNT - 1)) begin
            state_nxt = S_IDLE;
          end else if (state_r == S_L_DRAIN && layer_r == 4'(LAYER_COUNT - 1) &&
                       pos_r == 4'(PER_LAYER - 1)) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = (state_r == S_R_WB) ? S_R_TAP : S_L_ACT;
            if (!out_layer && pos_r == 4'(PER_LAYER - 1)) begin
              layer_nxt = layer_r + 4'd1;
              pos_nxt   = '0;
              base_nxt  = first ? '0 : base_r + 7'(PER_LAYER);
            end else begin
              pos_nxt = pos_r + 4'd1;
            end
          end
        end
      end
      S_L_ACT: begin
        cmd.z_rd  = 1'b1;
        state_nxt = S_L_MULZ;
      end
      S_L_MULZ: begin
        cmd.z_mul = 1'b1;
        state_nxt = S_L_Z;
      end
      S_L_Z: begin
        cmd.z_round = 1'b1;
        state_nxt   = S_L_TAB;
      end
      S_L_TAB: begin
        cmd.z_tab = 1'b1;
        state_nxt = S_L_RG;
      end
      S_L_RG: begin
        cmd.z_rg  = 1'b1;
        state_nxt = S_L_TAP;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      node_r  <= '0;
      layer_r <= '0;
      pos_r   <= '0;
      tap_r   <= '0;
      base_r  <= '0;
    end else begin
      state_r <= state_nxt;
      node_r  <= node_nxt;
      layer_r <= layer_nxt;
      pos_r   <= pos_nxt;
      tap_r   <= tap_nxt;
      base_r  <= base_nxt;
    end
  end

endmodule

// File: hdl/hlne_dp.sv
// ----------------------------------------------------------------------------
// hlne_dp
// Datapath: stores, tap pipeline with shared multiplier, logistic unit.
// ----------------------------------------------------------------------------
module hlne_dp import hlne_pkg::*; #(
  parameter int INPUT_COUNT  = 16,
  parameter int PER_LAYER    = 16,
  parameter int LAYER_COUNT  = 4,
  parameter int OUTPUT_COUNT = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  hlne_cmd_t          cmd,
  output hlne_stat_t         stat,
  input  logic [6:0]         in_neuron_index,
  input  logic [3:0]         in_tap_index,
  input  logic [3:0]         in_source_index,
  input  logic signed [15:0] in_value,
  input  logic signed [15:0] learn_rate,
  input  logic signed [15:0] logistic_gain,
  output logic               out_strobe,
  output logic [2:0]         out_output_number,
  output logic signed [15:0] out_value,
  output logic               out_last
);

  localparam int HIDDEN   = LAYER_COUNT * PER_LAYER;
  localparam int NODES    = HIDDEN + OUTPUT_COUNT;
  localparam int NODE_W   = $clog2(NODES);
  localparam int WS_AW    = NODE_W + TAP_W;
  localparam int WS_DEPTH = NODES * TAPS;
  localparam int ACT_AW   = (HIDDEN > 1) ? $clog2(HIDDEN) : 1;
  localparam int ACC_W    = 2 * VAL_W + TAP_W;
  localparam int WS_W     = VAL_W + TAP_W;

  // stores
  logic signed [15:0] in_store_r [TAPS];
  logic [WS_W-1:0]    wsm_mem [WS_DEPTH];
  logic signed [15:0] act_mem [2**ACT_AW];
  logic [2**ACT_AW-1:0] act_vld_r;

  // tap pipeline
  logic                 s1_v_r, s2_v_r, s3_v_r;
  logic [WS_AW-1:0]     s1_addr_r, s2_addr_r, s3_addr_r;
  logic [WS_W-1:0]      wsm_q_r;
  logic signed [15:0]   s2_w_r, s3_w_r;
  logic [3:0]           s2_src_r, s3_src_r;
  logic signed [15:0]   s2_in_r;
  logic                 s2_zero_r;
  logic signed [15:0]   act_q_r;
  logic                 act_qv_r;
  logic signed [45:0]   prod_r;
  logic signed [ACC_W-1:0] acc_r;

  // logistic unit
  logic signed [31:0] zprod_r;
  logic signed [15:0] z_r;
  logic [10:0]        tab_base_r;
  logic [21:0]        tab_frac_r;
  logic               tab_neg_r;
  logic signed [28:0] rg_r;

  logic [7:0]         ni_ext;
  logic               ld_we;
  logic [WS_AW-1:0]   ld_addr;
  logic [WS_AW-1:0]   rd_addr;
  logic [3:0]         s1_src;
  logic [7:0]         act_sum;
  logic [ACT_AW-1:0]  act_addr;
  logic signed [15:0] act_op;
  logic signed [15:0] operand;
  logic signed [28:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [45:0] d_full;
  logic signed [22:0] w_sum;
  logic signed [15:0] w_new;
  logic signed [ACC_W-1:0] rnd;
  logic signed [15:0] res;
  logic [15:0]        mag;
  logic [4:0]         idx;
  logic [10:0]        tab_a, tab_b;
  logic [11:0]        v_abs;
  logic signed [12:0] g;

  assign ni_ext  = {1'b0, in_neuron_index};
  assign ld_we   = cmd.wr_weight && (ni_ext < 8'(NODES));
  assign ld_addr = {ni_ext[NODE_W-1:0], in_tap_index};
  assign rd_addr = {cmd.node[NODE_W-1:0], cmd.tap};
  assign s1_src  = wsm_q_r[3:0];
  assign act_sum = 8'(cmd.prev_base) + 8'(s1_src);
  assign act_addr = cmd.z_rd ? cmd.node[ACT_AW-1:0] : act_sum[ACT_AW-1:0];
  assign act_op  = act_qv_r ? act_q_r : 16'sd0;
  assign operand = cmd.first_layer ? s2_in_r : (s2_zero_r ? 16'sd0 : act_op);
  assign mul_a   = cmd.learn ? rg_r : 29'(s2_w_r);
  assign mul_b   = cmd.learn ? (17'(operand) - 17'sd2048) : 17'(operand);

  // weight change: floor((p + 2^23) / 2^24)
  assign d_full  = (prod_r + 46'sd8388608) >>> 24;
  assign w_sum   = 23'(s3_w_r) + d_full[22:0];
  assign w_new   = sat16(48'(w_sum));

  assign rnd     = (acc_r + ACC_W'(2048)) >>> 12;
  assign res     = sat16(48'(rnd));

  assign mag     = z_r[15] ? (~z_r + 16'd1) : z_r;
  assign idx     = mag[15:11];
  assign tab_a   = half_logistic(idx);
  assign tab_b   = half_logistic(5'(idx + 5'd1));
  assign v_abs   = 12'(tab_base_r) + 12'(tab_frac_r[21:11]);
  assign g       = tab_neg_r ? -13'(v_abs) : 13'(v_abs);

  assign stat.pipe_empty = !s1_v_r && !s2_v_r && !s3_v_r;

  // input store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TAPS; i++) in_store_r[i] <= '0;
    end else if (cmd.wr_input && in_neuron_index < 7'(INPUT_COUNT)) begin
      in_store_r[in_neuron_index[3:0]] <= in_value;
    end
  end

  // weight and source memory
  always_ff @(posedge clk) begin
    if (ld_we) begin
      wsm_mem[ld_addr] <= {in_value, in_source_index};
    end else if (s3_v_r && cmd.learn) begin
      wsm_mem[s3_addr_r] <= {w_new, s3_src_r};
    end
    if (cmd.issue) wsm_q_r <= wsm_mem[rd_addr];
  end

  // activation memory
  always_ff @(posedge clk) begin
    if (cmd.wb && !cmd.wb_out) act_mem[cmd.node[ACT_AW-1:0]] <= res;
    if (cmd.z_rd || s1_v_r) act_q_r <= act_mem[act_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_vld_r <= '0;
      act_qv_r  <= 1'b0;
    end else begin
      if (cmd.wb && !cmd.wb_out) act_vld_r[cmd.node[ACT_AW-1:0]] <= 1'b1;
      if (cmd.z_rd || s1_v_r) act_qv_r <= act_vld_r[act_addr];
    end
  end

  // pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      acc_r  <= '0;
    end else begin
      s1_v_r <= cmd.issue;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      if (cmd.acc_clr) acc_r <= '0;
      else if (s3_v_r && !cmd.learn) acc_r <= acc_r + $signed(prod_r[ACC_W-1:0]);
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    s1_addr_r <= rd_addr;
    s2_addr_r <= s1_addr_r;
    s2_w_r    <= wsm_q_r[WS_W-1:TAP_W];
    s2_src_r  <= s1_src;
    s2_in_r   <= ({1'b0, s1_src} < 5'(INPUT_COUNT)) ? in_store_r[s1_src] : 16'sd0;
    s2_zero_r <= ({1'b0, s1_src} >= 5'(PER_LAYER));
    prod_r    <= mul_a * mul_b;
    s3_addr_r <= s2_addr_r;
    s3_w_r    <= s2_w_r;
    s3_src_r  <= s2_src_r;
  end

  // logistic unit
  always_ff @(posedge clk) begin
    if (cmd.z_mul)   zprod_r <= logistic_gain * act_op;
    if (cmd.z_round) z_r <= sat16(48'((zprod_r + 32'sd2048) >>> 12));
    if (cmd.z_tab) begin
      tab_base_r <= tab_a;
      tab_frac_r <= (tab_b - tab_a) * mag[10:0];
      tab_neg_r  <= z_r[15];
    end
    if (cmd.z_rg) rg_r <= learn_rate * g;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= cmd.wb && cmd.wb_out;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wb) begin
      out_output_number <= cmd.out_num;
      out_value         <= res;
      out_last          <= cmd.out_last;
    end
  end

endmodule

// File: hdl/hebbian_layered_net_engine.sv
// ----------------------------------------------------------------------------
// hebbian_layered_net_engine
// Layered network with Hebbian update; config registers on an APB port.
// ----------------------------------------------------------------------------
// Set-input and load items never raise busy. A run item walks every neurode
// tap by tap through the single shared multiply-accumulate pipeline.
// A learn item walks each hidden neurode through the logistic unit and then
// through the same pipeline. Results leave one per output neurode, one cycle
// each; the receiver cannot stall. Synchronous reset clears control and
// inputs, invalidates activations and presets the config registers.
module hebbian_layered_net_engine import hlne_pkg::*; #(
  parameter int INPUT_COUNT  = 16,
  parameter int PER_LAYER    = 16,
  parameter int LAYER_COUNT  = 4,
  parameter int OUTPUT_COUNT = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_op,
  input  logic [6:0]         in_neuron_index,
  input  logic [3:0]         in_tap_index,
  input  logic [3:0]         in_source_index,
  input  logic signed [15:0] in_value,
  output logic               out_strobe,
  output logic [2:0]         out_output_number,
  output logic signed [15:0] out_value,
  output logic               out_last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic signed [15:0] learn_rate_r;
  logic signed [15:0] logistic_gain_r;
  hlne_cmd_t          cmd;
  hlne_stat_t         stat;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'(logistic_gain_r) : 32'(learn_rate_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      learn_rate_r    <= 16'sd205;
      logistic_gain_r <= -16'sd4096;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) logistic_gain_r <= pwdata[15:0];
      else learn_rate_r <= pwdata[15:0];
    end
  end

  hlne_ctrl #(
    .INPUT_COUNT (INPUT_COUNT),
    .PER_LAYER   (PER_LAYER),
    .LAYER_COUNT (LAYER_COUNT),
    .OUTPUT_COUNT(OUTPUT_COUNT)
  ) u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .op   (in_op),
    .stat (stat),
    .busy (busy),
    .cmd  (cmd)
  );

  hlne_dp #(
    .INPUT_COUNT (INPUT_COUNT),
    .PER_LAYER   (PER_LAYER),
    .LAYER_COUNT (LAYER_COUNT),
    .OUTPUT_COUNT(OUTPUT_COUNT)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_neuron_index  (in_neuron_index),
    .in_tap_index     (in_tap_index),
    .in_source_index  (in_source_index),
    .in_value         (in_value),
    .learn_rate       (learn_rate_r),
    .logistic_gain    (logistic_gain_r),
    .out_strobe       (out_strobe),
    .out_output_number(out_output_number),
    .out_value        (out_value),
    .out_last         (out_last)
  );

  a_strobe_from_pass: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result strobe outside a pass");

  a_run_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_op == OP_RUN || in_op == OP_LEARN)) |=> busy)
    else $error("run or learn item did not start");

  a_last_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_last && out_strobe |-> out_output_number == 3'(OUTPUT_COUNT - 1))
    else $error("last marker on wrong output");

  a_pipe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> stat.pipe_empty)
    else $error("tap pipeline active while idle");

endmodule
